>>> rtl/hmf_pkg.sv
// Package for the HTTP message framer: payload types, codes and constants.
`default_nettype none
package hmf_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
    } hmf_in_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic        body_byte;
        logic [2:0]  error_code;
        logic        message_done;
        logic [9:0]  status_value;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
        logic        chunked_body;
        logic        close_after;
        logic [31:0] body_total;
    } hmf_out_t;

    localparam logic [2:0] ROLE_START   = 3'd0;
    localparam logic [2:0] ROLE_HEADER  = 3'd1;
    localparam logic [2:0] ROLE_BODY    = 3'd2;
    localparam logic [2:0] ROLE_CSIZE   = 3'd3;
    localparam logic [2:0] ROLE_CEND    = 3'd4;
    localparam logic [2:0] ROLE_TRAILER = 3'd5;
    localparam logic [2:0] ROLE_PAST    = 3'd6;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_START  = 3'd1;
    localparam logic [2:0] ERR_HEADER = 3'd2;
    localparam logic [2:0] ERR_CEND   = 3'd3;
    localparam logic [2:0] ERR_NUMBER = 3'd4;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    // 16 means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (is_digit(c)) return {1'b0, c[3:0]};
        if (l >= 8'h61 && l <= 8'h66) return 5'(l - 8'h57);
        return 5'd16;
    endfunction

    function automatic logic [7:0] proto_char(input logic [4:0] i);
        case (i)
            5'd0: return 8'h48;
            5'd1: return 8'h54;
            5'd2: return 8'h54;
            5'd3: return 8'h50;
            5'd4: return 8'h2f;
            default: return 8'h00;
        endcase
    endfunction

    // header names, lower case; index k selects the word
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [4:0] i);
        logic [8*17-1:0] w;
        case (k)
            2'd0: w = {"content-length", 24'h0};
            2'd1: w = "transfer-encoding";
            default: w = {"connection", 56'h0};
        endcase
        if (i > 5'd16) return 8'h00;
        return w[8*(16-i) +: 8];
    endfunction

    function automatic logic [4:0] name_len(input logic [1:0] k);
        case (k)
            2'd0: return 5'd14;
            2'd1: return 5'd17;
            default: return 5'd10;
        endcase
    endfunction

    function automatic logic [7:0] value_char(input logic chunked, input logic [4:0] i);
        logic [8*7-1:0] w;
        w = chunked ? "chunked" : {"close", 16'h0};
        if (i > 5'd6) return 8'h00;
        return w[8*(6-i) +: 8];
    endfunction

endpackage
`default_nettype wire

>>> rtl/hmf_accum.sv
// Saturating decimal/hex digit accumulator step for length and size values.
`default_nettype none
module hmf_accum import hmf_pkg::*; #(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
    input  wire logic [LENGTH_WIDTH-1:0] acc,
    input  wire logic                    hex,
    input  wire logic [3:0]              digit,
    output logic [LENGTH_WIDTH-1:0]      acc_next,
    output logic                         overflow
);
    logic [LENGTH_WIDTH+4:0] prod;

    always_comb begin
        if (hex) begin
            prod = {acc, 4'd0} + (LENGTH_WIDTH+5)'(digit);
        end else begin
            prod = ({1'b0, acc, 3'd0}) + (LENGTH_WIDTH+5)'({acc, 1'b0})
                 + (LENGTH_WIDTH+5)'(digit);
        end
        overflow = |prod[LENGTH_WIDTH+4:LENGTH_WIDTH];
        acc_next = overflow ? {LENGTH_WIDTH{1'b1}} : prod[LENGTH_WIDTH-1:0];
    end
endmodule
`default_nettype wire

>>> rtl/http_message_framer.sv
// Top level of the HTTP/1.x message framer.
//
// Bytes arrive on s_ (valid/ready) with a start_new flag that begins a new
// message before that byte is taken. Every byte yields one result item on m_
// giving its role, body flag, sticky error, done flag and the parsed version,
// status code, chunked/close flags and body byte count.
// message_kind (cfg_we/cfg_wdata) selects request (1) or response (0) parsing;
// write it only while the block is idle.
// The result for a byte is registered and shown in the cycle after it
// is accepted. Throughput is one byte per cycle unless the receiver stalls,
// set by the combinational parser state update before the result register.
// If the receiver stalls, the result register holds and s_ready stays high
// only while the result register is free or being emptied that cycle.
// Reset clears all parser state, message_kind to response, and drops any
// pending result.
`default_nettype none
module http_message_framer import hmf_pkg::*; #(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire hmf_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output hmf_out_t      m_data
);
    typedef enum logic [2:0] {
        PH_START, PH_HEADERS, PH_LENGTH, PH_CHUNKED, PH_TRAILER, PH_DONE
    } phase_t;
    typedef enum logic [1:0] {CK_SIZE, CK_DATA, CK_END} chunk_t;
    typedef enum logic [4:0] {
        SL_FIRST, SL_RPROTO, SL_RMAJ, SL_RDOT, SL_RMIN, SL_RSP, SL_SFIRST, SL_SMORE,
        SL_REASON, SL_METH, SL_PFIRST, SL_PMORE, SL_QPROTO, SL_QMAJ, SL_QDOT, SL_QMIN,
        SL_QEND, HL_START, HL_NAME, HL_WS, HL_VALUE, HL_FOLD, CS_START, CS_DIGITS,
        CS_EXT
    } line_t;

    localparam logic [2:0] NM_CL = 3'b001, NM_TE = 3'b010, NM_CONN = 3'b100;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    logic                    kind_reg;
    phase_t                  phase_reg, phase_next;
    chunk_t                  ck_reg, ck_next;
    line_t                   line_reg, line_next;
    logic [2:0]              names_reg, names_next;
    logic [4:0]              pos_reg, pos_next;
    logic [1:0]              vals_reg, vals_next;
    logic [LENGTH_WIDTH-1:0] dlen_reg, dlen_next, body_reg, body_next;
    logic [LENGTH_WIDTH-1:0] csize_reg, csize_next, coff_reg, coff_next;
    logic [LENGTH_WIDTH-1:0] acc_reg, acc_next;
    logic                    lseen_reg, lseen_next;
    logic [1:0]              chm_reg, chm_next, clm_reg, clm_next;
    logic [9:0]              status_reg, status_next;
    logic [7:0]              ver_reg, ver_next;
    logic [2:0]              err_reg, err_next;
    hmf_out_t                out_reg, out_next;
    logic                    mv_reg;

    logic [LENGTH_WIDTH-1:0] ac_in, ac_out;
    logic                    ac_hex, ac_ovf;
    logic [3:0]              ac_dig;

    hmf_accum #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_accum (
        .acc(ac_in), .hex(ac_hex), .digit(ac_dig), .acc_next(ac_out), .overflow(ac_ovf)
    );

    logic take;
    assign s_ready = !mv_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [7:0]  c;
        logic [2:0]  role;
        logic        body, ok, trailer;
        logic [4:0]  h;
        logic [13:0] sv;
        c = s_data.data_byte;
        ac_in = acc_reg; ac_hex = 1'b0; ac_dig = c[3:0];
        h = hex_value(c);
        sv = 14'd0;
        phase_next = phase_reg; ck_next = ck_reg; line_next = line_reg;
        names_next = names_reg; pos_next = pos_reg; vals_next = vals_reg;
        dlen_next = dlen_reg; body_next = body_reg; csize_next = csize_reg;
        coff_next = coff_reg; acc_next = acc_reg; lseen_next = lseen_reg;
        chm_next = chm_reg; clm_next = clm_reg; status_next = status_reg;
        ver_next = ver_reg; err_next = err_reg;
        if (s_data.start_new) begin
            phase_next = PH_START; ck_next = CK_SIZE; line_next = SL_FIRST;
            names_next = 3'b111; pos_next = 5'd0; vals_next = 2'd3;
            dlen_next = '0; body_next = '0; csize_next = '0; coff_next = '0;
            acc_next = '0; lseen_next = 1'b0; chm_next = 2'd0; clm_next = 2'd0;
            status_next = '0; ver_next = '0; err_next = ERR_NONE;
        end
        ac_in = acc_next;
        role = ROLE_PAST; body = 1'b0; ok = 1'b1;
        trailer = (phase_next == PH_TRAILER);
        if (err_next == ERR_NONE) begin
            case (phase_next)
                PH_START: begin
                    role = ROLE_START;
                    if (c == CH_LF) begin
                        if (line_next == SL_REASON || line_next == SL_QEND) begin
                            phase_next = PH_HEADERS; line_next = HL_START;
                        end else begin
                            ok = 1'b0;
                        end
                    end else if (c != CH_CR) begin
                        case (line_next)
                            SL_FIRST: begin
                                if (kind_reg) begin
                                    ok = is_letter(c); line_next = SL_METH;
                                end else begin
                                    ok = (c == proto_char(5'd0));
                                    pos_next = ok ? 5'd1 : 5'd0;
                                    line_next = SL_RPROTO;
                                end
                            end
                            SL_RPROTO, SL_QPROTO: begin
                                ok = pos_next < 5'd5 && c == proto_char(pos_next);
                                if (ok) begin
                                    pos_next = pos_next + 5'd1;
                                    if (pos_next >= 5'd5)
                                        line_next = (line_next == SL_RPROTO) ? SL_RMAJ
                                                                             : SL_QMAJ;
                                end
                            end
                            SL_RMAJ, SL_QMAJ: begin
                                ok = is_digit(c);
                                ver_next[7:4] = 4'(c - 8'h30);
                                line_next = (line_next == SL_RMAJ) ? SL_RDOT : SL_QDOT;
                            end
                            SL_RDOT, SL_QDOT: begin
                                ok = (c == CH_DOT);
                                line_next = (line_next == SL_RDOT) ? SL_RMIN : SL_QMIN;
                            end
                            SL_RMIN, SL_QMIN: begin
                                ok = is_digit(c);
                                ver_next[3:0] = 4'(c - 8'h30);
                                line_next = (line_next == SL_RMIN) ? SL_RSP : SL_QEND;
                            end
                            SL_RSP: begin
                                ok = (c == CH_SP); line_next = SL_SFIRST;
                            end
                            SL_SFIRST: begin
                                ok = is_digit(c);
                                // a non-digit wraps below zero at the field width
                                status_next = 10'(c) - 10'd48;
                                line_next = SL_SMORE;
                            end
                            SL_SMORE: begin
                                if (c == CH_SP) line_next = SL_REASON;
                                else if (!is_digit(c)) ok = 1'b0;
                                else begin
                                    sv = 14'({status_next, 3'd0}) + 14'({status_next, 1'b0})
                                       + 14'(c[3:0]);
                                    if (sv > 14'd999) begin
                                        sv = 14'd999; err_next = ERR_NUMBER;
                                    end
                                    status_next = sv[9:0];
                                end
                            end
                            SL_REASON: ;
                            SL_METH: begin
                                if (c == CH_SP) line_next = SL_PFIRST;
                                else ok = is_letter(c);
                            end
                            SL_PFIRST: begin
                                ok = (c != CH_SP); line_next = SL_PMORE;
                            end
                            SL_PMORE: begin
                                if (c == CH_SP) begin
                                    pos_next = 5'd0; line_next = SL_QPROTO;
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                    if (!ok && err_next == ERR_NONE) err_next = ERR_START;
                end
                PH_HEADERS, PH_TRAILER: begin
                    role = trailer ? ROLE_TRAILER : ROLE_HEADER;
                    if (c != CH_CR) begin
                        case (line_next)
                            HL_START: begin
                                if (c == CH_LF) begin
                                    if (trailer) phase_next = PH_DONE;
                                    else if (chm_next == 2'd2) begin
                                        phase_next = PH_CHUNKED; ck_next = CK_SIZE;
                                        line_next = CS_START; acc_next = '0;
                                    end else if (!lseen_next || dlen_next == '0)
                                        phase_next = PH_DONE;
                                    else phase_next = PH_LENGTH;
                                end else if (c == CH_SP || c == CH_HT) begin
                                    line_next = HL_FOLD;
                                end else if (c == CH_COLON) begin
                                    err_next = ERR_HEADER;
                                end else begin
                                    line_next = HL_NAME;
                                    names_next = trailer ? 3'b000 : 3'b111;
                                    for (int k = 0; k < 3; k++)
                                        if (to_lower(c) != name_char(2'(k), 5'd0))
                                            names_next[k] = 1'b0;
                                    pos_next = 5'd1;
                                end
                            end
                            HL_NAME: begin
                                if (c == CH_LF) err_next = ERR_HEADER;
                                else if (c == CH_COLON) begin
                                    for (int k = 0; k < 3; k++)
                                        if (pos_next != name_len(2'(k)))
                                            names_next[k] = 1'b0;
                                    vals_next = (names_next == NM_TE) ? 2'd1 :
                                                (names_next == NM_CONN) ? 2'd2 : 2'd0;
                                    pos_next = 5'd0; acc_next = '0;
                                    line_next = HL_WS;
                                end else begin
                                    for (int k = 0; k < 3; k++)
                                        if (!(pos_next < name_len(2'(k)) &&
                                              to_lower(c) == name_char(2'(k), pos_next)))
                                            names_next[k] = 1'b0;
                                    if (pos_next < 5'd31) pos_next = pos_next + 5'd1;
                                end
                            end
                            HL_WS, HL_VALUE: begin
                                if (c == CH_LF) begin
                                    line_next = HL_START;
                                    if (names_next == NM_CL) begin
                                        if (pos_next == 5'd0) err_next = ERR_NUMBER;
                                        else begin
                                            dlen_next = acc_next; lseen_next = 1'b1;
                                        end
                                    end else if (names_next == NM_TE) begin
                                        chm_next = (vals_next != 2'd0 && pos_next == 5'd7)
                                                 ? 2'd2 : 2'd1;
                                    end else if (names_next == NM_CONN) begin
                                        clm_next = (vals_next != 2'd0 && pos_next == 5'd5)
                                                 ? 2'd2 : 2'd1;
                                    end
                                end else if (line_next == HL_VALUE ||
                                             (c != CH_SP && c != CH_HT)) begin
                                    line_next = HL_VALUE;
                                    if (names_next == NM_CL) begin
                                        if (is_digit(c)) begin
                                            acc_next = ac_out;
                                            if (ac_ovf) err_next = ERR_NUMBER;
                                            if (pos_next < 5'd31) pos_next = pos_next + 5'd1;
                                        end else err_next = ERR_NUMBER;
                                    end else if (vals_next != 2'd0) begin
                                        if (!(pos_next < ((vals_next == 2'd1) ? 5'd7 : 5'd5)
                                              && to_lower(c) ==
                                                 value_char(vals_next == 2'd1, pos_next)))
                                            vals_next = 2'd0;
                                        if (pos_next < 5'd31) pos_next = pos_next + 5'd1;
                                    end
                                end
                            end
                            default: if (c == CH_LF) line_next = HL_START;
                        endcase
                    end
                end
                PH_LENGTH: begin
                    role = ROLE_BODY; body = 1'b1;
                    if (body_next == LEN_MAX) err_next = ERR_NUMBER;
                    else body_next = body_next + 1'b1;
                    if (body_next >= dlen_next) phase_next = PH_DONE;
                end
                PH_CHUNKED: begin
                    case (ck_next)
                        CK_DATA: begin
                            role = ROLE_BODY; body = 1'b1;
                            if (body_next == LEN_MAX) err_next = ERR_NUMBER;
                            else body_next = body_next + 1'b1;
                            coff_next = coff_next + 1'b1;
                            if (coff_next >= csize_next) ck_next = CK_END;
                        end
                        CK_END: begin
                            role = ROLE_CEND;
                            if (c == CH_LF) begin
                                ck_next = CK_SIZE; line_next = CS_START; acc_next = '0;
                            end else if (c != CH_CR) err_next = ERR_CEND;
                        end
                        default: begin
                            role = ROLE_CSIZE;
                            ac_hex = 1'b1; ac_dig = h[3:0];
                            if (c == CH_CR) ;
                            else if (line_next == CS_DIGITS || line_next == CS_EXT) begin
                                if (c == CH_LF) begin
                                    if (acc_next == '0) begin
                                        phase_next = PH_TRAILER; line_next = HL_START;
                                    end else begin
                                        csize_next = acc_next; coff_next = '0;
                                        ck_next = CK_DATA;
                                    end
                                end else if (line_next == CS_DIGITS) begin
                                    if (!h[4]) begin
                                        acc_next = ac_out;
                                        if (ac_ovf) err_next = ERR_NUMBER;
                                    end else line_next = CS_EXT;
                                end
                            end else begin
                                if (!h[4]) begin
                                    acc_next = LENGTH_WIDTH'(h[3:0]); line_next = CS_DIGITS;
                                end else err_next = ERR_NUMBER;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
        out_next.byte_role     = role;
        out_next.body_byte     = body;
        out_next.error_code    = err_next;
        out_next.message_done  = (phase_next == PH_DONE) && (err_next == ERR_NONE);
        out_next.status_value  = status_next;
        out_next.version_major = ver_next[7:4];
        out_next.version_minor = ver_next[3:0];
        out_next.chunked_body  = (chm_next == 2'd2);
        out_next.close_after   = (clm_next == 2'd2);
        out_next.body_total    = 32'(body_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 1'b0; mv_reg <= 1'b0;
            phase_reg <= PH_START; ck_reg <= CK_SIZE; line_reg <= SL_FIRST;
            names_reg <= 3'b111; pos_reg <= '0; vals_reg <= 2'd3;
            dlen_reg <= '0; body_reg <= '0; csize_reg <= '0; coff_reg <= '0;
            acc_reg <= '0; lseen_reg <= 1'b0; chm_reg <= '0; clm_reg <= '0;
            status_reg <= '0; ver_reg <= '0; err_reg <= ERR_NONE;
        end else begin
            if (cfg_we) kind_reg <= cfg_wdata;
            if (take) begin
                phase_reg <= phase_next; ck_reg <= ck_next; line_reg <= line_next;
                names_reg <= names_next; pos_reg <= pos_next; vals_reg <= vals_next;
                dlen_reg <= dlen_next; body_reg <= body_next; csize_reg <= csize_next;
                coff_reg <= coff_next; acc_reg <= acc_next; lseen_reg <= lseen_next;
                chm_reg <= chm_next; clm_reg <= clm_next; status_reg <= status_next;
                ver_reg <= ver_next; err_reg <= err_next;
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) out_reg <= out_next;
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the HTTP message framer: directed and random byte streams.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import hmf_pkg::*;

    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;

    // parser phases
    typedef enum logic [2:0] {
        PH_START, PH_HEADERS, PH_LENGTH, PH_CHUNKED, PH_TRAILER, PH_DONE
    } phase_t;
    typedef enum logic [1:0] { CK_SIZE, CK_DATA, CK_END } cphase_t;
    typedef enum logic [4:0] {
        SL_FIRST, SL_RPROTO, SL_RMAJ, SL_RDOT, SL_RMIN, SL_RSP, SL_SFIRST, SL_SMORE,
        SL_REASON, SL_METH, SL_PFIRST, SL_PMORE, SL_QPROTO, SL_QMAJ, SL_QDOT, SL_QMIN,
        SL_QEND, HL_START, HL_NAME, HL_WS, HL_VALUE, HL_FOLD, CS_START, CS_DIGITS, CS_EXT
    } lm_t;
    localparam logic [2:0] NM_CL = 3'd1, NM_TE = 3'd2, NM_CONN = 3'd4;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hmf_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hmf_out_t m_data;

    http_message_framer dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic        kind_q;
    phase_t      ph;
    cphase_t     cph;
    lm_t         lm;
    logic [2:0]  names;
    logic [4:0]  tpos;
    logic [1:0]  vals;
    logic [63:0] decl_len, body_cnt, csize, coff, acc;
    logic        len_seen;
    logic [1:0]  te_mode, conn_mode;
    logic [2:0]  err;
    logic [9:0]  status_q;
    logic [7:0]  ver_q;

    hmf_out_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int cycles = 0;

    function automatic logic digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic letter_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic [7:0] lower_c(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction
    function automatic logic [4:0] hexval(logic [7:0] c);
        logic [7:0] l;
        l = lower_c(c);
        if (digit_c(c)) return 5'(c - "0");
        if (l >= "a" && l <= "f") return 5'(l - "a" + 10);
        return 5'd16;
    endfunction

    function automatic void flag(logic [2:0] code);
        if (err == ERR_NONE) err = code;
    endfunction

    function automatic void accum(logic [63:0] base, logic [63:0] d);
        if (acc > (LEN_MAX - d) / base) begin
            acc = LEN_MAX;
            flag(ERR_NUMBER);
        end else begin
            acc = acc * base + d;
        end
    endfunction

    function automatic void clear_parser();
        ph = PH_START; cph = CK_SIZE; lm = SL_FIRST; names = 3'd7; tpos = 0; vals = 2'd3;
        decl_len = 0; len_seen = 0; te_mode = 0; conn_mode = 0; body_cnt = 0;
        csize = 0; coff = 0; acc = 0; status_q = 0; ver_q = 0; err = ERR_NONE;
    endfunction

    function automatic logic proto_ok(logic [7:0] c, lm_t nxt);
        string p;
        p = "HTTP/";
        if (tpos < 5 && c == p[tpos]) begin
            tpos++;
            if (tpos >= 5) lm = nxt;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_line(logic [7:0] c);
        logic ok;
        ok = 1'b1;
        if (c == CH_LF) begin
            if (lm == SL_REASON || lm == SL_QEND) begin
                ph = PH_HEADERS; lm = HL_START;
            end else flag(ERR_START);
            return;
        end
        case (lm)
            SL_FIRST: begin
                if (kind_q) begin
                    ok = letter_c(c); lm = SL_METH;
                end else begin
                    tpos = 0; lm = SL_RPROTO; ok = proto_ok(c, SL_RMAJ);
                end
            end
            SL_RPROTO: ok = proto_ok(c, SL_RMAJ);
            SL_QPROTO: ok = proto_ok(c, SL_QMAJ);
            SL_RMAJ, SL_QMAJ: begin
                ok = digit_c(c);
                ver_q[7:4] = 4'(c - "0");
                lm = (lm == SL_RMAJ) ? SL_RDOT : SL_QDOT;
            end
            SL_RDOT, SL_QDOT: begin
                ok = (c == CH_DOT);
                lm = (lm == SL_RDOT) ? SL_RMIN : SL_QMIN;
            end
            SL_RMIN, SL_QMIN: begin
                ok = digit_c(c);
                ver_q[3:0] = 4'(c - "0");
                lm = (lm == SL_RMIN) ? SL_RSP : SL_QEND;
            end
            SL_RSP: begin
                ok = (c == CH_SP); lm = SL_SFIRST;
            end
            SL_SFIRST: begin
                ok = digit_c(c); status_q = 10'(16'(c) - 16'd48); lm = SL_SMORE;
            end
            SL_SMORE: begin
                if (c == CH_SP) lm = SL_REASON;
                else if (!digit_c(c)) ok = 1'b0;
                else begin
                    int v;
                    v = int'(status_q) * 10 + int'(c - "0");
                    if (v > 999) begin
                        v = 999; flag(ERR_NUMBER);
                    end
                    status_q = 10'(v);
                end
            end
            SL_REASON: ;
            SL_METH: begin
                if (c == CH_SP) lm = SL_PFIRST;
                else ok = letter_c(c);
            end
            SL_PFIRST: begin
                ok = (c != CH_SP); lm = SL_PMORE;
            end
            SL_PMORE: begin
                if (c == CH_SP) begin
                    tpos = 0; lm = SL_QPROTO;
                end
            end
            default: ok = 1'b0;
        endcase
        if (!ok) flag(ERR_START);
    endfunction

    function automatic string hdr_word(int k);
        case (k)
            0: return "content-length";
            1: return "transfer-encoding";
            default: return "connection";
        endcase
    endfunction

    function automatic void bump();
        if (tpos < 31) tpos++;
    endfunction

    function automatic void name_step(logic [7:0] c);
        string w;
        for (int k = 0; k < 3; k++) begin
            w = hdr_word(k);
            if (names[k] && !(tpos < w.len() && lower_c(c) == w[tpos])) names[k] = 1'b0;
        end
        bump();
    endfunction

    function automatic void value_step(logic [7:0] c);
        string w;
        if (names == NM_CL) begin
            if (digit_c(c)) begin
                accum(10, 64'(c - "0")); bump();
            end else flag(ERR_NUMBER);
        end else if (vals != 0) begin
            if (vals == 1) w = "chunked";
            else w = "close";
            if (!(tpos < w.len() && lower_c(c) == w[tpos])) vals = 0;
            bump();
        end
    endfunction

    function automatic void end_value();
        lm = HL_START;
        if (names == NM_CL) begin
            if (tpos == 0) flag(ERR_NUMBER);
            else begin
                decl_len = acc; len_seen = 1;
            end
        end else if (names == NM_TE) te_mode = (vals != 0 && tpos == 7) ? 2'd2 : 2'd1;
        else if (names == NM_CONN) conn_mode = (vals != 0 && tpos == 5) ? 2'd2 : 2'd1;
    endfunction

    function automatic void header_line(logic [7:0] c, logic trailer);
        string w;
        case (lm)
            HL_START: begin
                if (c == CH_LF) begin
                    if (trailer) ph = PH_DONE;
                    else if (te_mode == 2) begin
                        ph = PH_CHUNKED; cph = CK_SIZE; lm = CS_START; acc = 0;
                    end else if (!len_seen || decl_len == 0) ph = PH_DONE;
                    else ph = PH_LENGTH;
                end else if (c == CH_SP || c == CH_HT) lm = HL_FOLD;
                else if (c == CH_COLON) flag(ERR_HEADER);
                else begin
                    lm = HL_NAME; tpos = 0; names = trailer ? 3'd0 : 3'd7;
                    name_step(c);
                end
            end
            HL_NAME: begin
                if (c == CH_LF) flag(ERR_HEADER);
                else if (c == CH_COLON) begin
                    for (int k = 0; k < 3; k++) begin
                        w = hdr_word(k);
                        if (tpos != w.len()) names[k] = 1'b0;
                    end
                    vals = (names == NM_TE) ? 2'd1 : (names == NM_CONN) ? 2'd2 : 2'd0;
                    tpos = 0; acc = 0; lm = HL_WS;
                end else name_step(c);
            end
            HL_WS: begin
                if (c == CH_LF) end_value();
                else if (c != CH_SP && c != CH_HT) begin
                    lm = HL_VALUE; value_step(c);
                end
            end
            HL_VALUE: begin
                if (c == CH_LF) end_value();
                else value_step(c);
            end
            default: if (c == CH_LF) lm = HL_START;
        endcase
    endfunction

    function automatic void count_body();
        if (body_cnt >= LEN_MAX) flag(ERR_NUMBER);
        else body_cnt++;
    endfunction

    function automatic hmf_out_t frame_byte(hmf_in_t item);
        hmf_out_t r;
        logic [7:0] c;
        logic [4:0] h;
        c = item.data_byte;
        r = '0;
        r.byte_role = ROLE_PAST;
        if (item.start_new) clear_parser();
        if (err == ERR_NONE) begin
            case (ph)
                PH_START: begin
                    r.byte_role = ROLE_START; if (c != CH_CR) start_line(c);
                end
                PH_HEADERS: begin
                    r.byte_role = ROLE_HEADER; if (c != CH_CR) header_line(c, 1'b0);
                end
                PH_LENGTH: begin
                    r.byte_role = ROLE_BODY; r.body_byte = 1'b1;
                    count_body();
                    if (body_cnt >= decl_len) ph = PH_DONE;
                end
                PH_CHUNKED: begin
                    if (cph == CK_DATA) begin
                        r.byte_role = ROLE_BODY; r.body_byte = 1'b1;
                        count_body();
                        coff++;
                        if (coff >= csize) cph = CK_END;
                    end else if (cph == CK_END) begin
                        r.byte_role = ROLE_CEND;
                        if (c == CH_LF) begin
                            cph = CK_SIZE; lm = CS_START; acc = 0;
                        end else if (c != CH_CR) flag(ERR_CEND);
                    end else begin
                        r.byte_role = ROLE_CSIZE;
                        h = hexval(c);
                        if (c == CH_CR) ;
                        else if (lm == CS_DIGITS || lm == CS_EXT) begin
                            if (c == CH_LF) begin
                                if (acc == 0) begin
                                    ph = PH_TRAILER; lm = HL_START;
                                end else begin
                                    csize = acc; coff = 0; cph = CK_DATA;
                                end
                            end else if (lm == CS_DIGITS) begin
                                if (h < 16) accum(16, 64'(h));
                                else lm = CS_EXT;
                            end
                        end else begin
                            if (h < 16) begin
                                acc = 64'(h); lm = CS_DIGITS;
                            end else flag(ERR_NUMBER);
                        end
                    end
                end
                PH_TRAILER: begin
                    r.byte_role = ROLE_TRAILER; if (c != CH_CR) header_line(c, 1'b1);
                end
                default: ;
            endcase
        end
        r.error_code = err;
        r.message_done = (ph == PH_DONE && err == ERR_NONE);
        r.status_value = status_q;
        r.version_major = ver_q[7:4];
        r.version_minor = ver_q[3:0];
        r.chunked_body = (te_mode == 2);
        r.close_after = (conn_mode == 2);
        r.body_total = body_cnt[31:0];
        return r;
    endfunction

    // sender; valid stays up between back-to-back items
    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{data_byte: b, start_new: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(frame_byte('{data_byte: b, start_new: first}));
    endtask

    task automatic send_text(string t, logic fresh);
        for (int i = 0; i < t.len(); i++) send_byte(t[i], fresh && i == 0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_kind(logic k);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(posedge aclk);
        cfg_we <= 1'b0;
        kind_q = k;
    endtask

    // receiver
    initial begin
        int stall;
        hmf_out_t want;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = expected_results.pop_front();
                if (m_data !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h actual %h (role %0d/%0d err %0d/%0d)",
                                 want, m_data, want.byte_role, m_data.byte_role,
                                 want.error_code, m_data.error_code);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic test_responses();
        set_kind(1'b0);
        send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\nConnection: close\r\n\r\nab\r", 1);
        send_text("XY", 0);
        send_text("HTTP/9.0 999 x\nTransfer-Encoding: CHUNKED\n\n1a;ext\r\n", 1);
        for (int i = 0; i < 26; i++) send_byte(8'(i * 37), 0);
        send_text("\r\n0\r\nx-t: v\r\n \tfold\r\n\r\n", 0);
        send_text("HTTP/0.9 1000 big\n", 1);
        send_text("HTTP/1.1 204\n", 1);
        send_text("http/1.1 200 ok\n", 1);
        send_text("HTTP/1.1 200 ok\n: bad\n", 1);
        send_text("HTTP/1.1 200 ok\nnocolon\n", 1);
        send_text("HTTP/1.1 200 ok\nContent-Length: 99999999999\n", 1);
        send_text("HTTP/1.1 200 ok\nContent-Length:\n", 1);
        send_text("HTTP/1.1 200 ok\nContent-Length: 1x\n", 1);
        send_text("HTTP/1.1 200 ok\nTransfer-Encoding: chunked\n\n2\nabZ", 1);
        send_text("HTTP/1.1 200 ok\nTransfer-Encoding: chunked\n\ng\n", 1);
        send_text("HTTP/1.1 200 ok\nTransfer-Encoding: chunked\n\n123456789\n", 1);
        send_text("HTTP/1.1 200 ok\nTransfer-Encoding: chunked \nConnection: closed\n\n", 1);
        send_text("HTTP/1.1 200 ok\nContent-Length: ffffffff\n", 1);
        send_text("HTTP/1.1 200 ok\nContent-Length: 4294967295\n\nab", 1);
        send_byte(8'hff, 0);
        send_byte(8'h00, 1);
    endtask

    task automatic test_requests();
        set_kind(1'b1);
        send_text("GET /index HTTP/1.0\r\nConnection: Close\r\nContent-Length: 2\r\n\r\nhi", 1);
        send_text("POST  / HTTP/1.1\n", 1);
        send_text("G3T / HTTP/1.1\n", 1);
        send_text("GET / HTTP/1.1x\n", 1);
        send_text("GET / HTTP/1\n", 1);
    endtask

    // build one message with random content
    function automatic string hexstr(int v);
        return $sformatf(($urandom_range(0, 1)) ? "%0h" : "%0H", v);
    endfunction

    function automatic string eol();
        string s;
        if ($urandom_range(0, 1) != 0) s = "\r\n";
        else s = "\n";
        return s;
    endfunction

    function automatic string random_message(logic req);
        string m, body, conn, ext;
        int n, chunked;
        chunked = $urandom_range(0, 1);
        if (req) m = {"GET /p", hexstr($urandom_range(0, 99)), " HTTP/1.1", eol()};
        else m = $sformatf("HTTP/%0d.%0d %0d R%s", $urandom_range(0, 9), $urandom_range(0, 9),
                           $urandom_range(0, 1200), eol());
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 2) != 0) conn = "close";
            else conn = "keep";
            m = {m, "cOnNeCtIoN:\t", conn, eol()};
        end
        if ($urandom_range(0, 3) == 0) m = {m, " folded", eol()};
        m = {m, "X-H: ", hexstr($urandom), eol()};
        if (chunked) begin
            m = {m, "Transfer-Encoding: chunked", eol(), eol()};
            repeat ($urandom_range(0, 3)) begin
                n = $urandom_range(1, 12);
                if ($urandom_range(0, 3) == 0) ext = ";e=1";
                else ext = "";
                m = {m, hexstr(n), ext, eol()};
                for (int i = 0; i < n; i++) m = {m, string'(8'($urandom_range(1, 255)))};
                m = {m, eol()};
            end
            m = {m, "0", eol()};
            if ($urandom_range(0, 1)) m = {m, "T: x", eol()};
            m = {m, eol()};
        end else begin
            n = $urandom_range(0, 20);
            m = {m, $sformatf("Content-Length: %0d", n), eol(), eol()};
            for (int i = 0; i < n; i++) m = {m, string'(8'($urandom_range(1, 255)))};
        end
        return m;
    endfunction

    task automatic test_random_traffic();
        int sent;
        string m;
        logic k;
        sent = 0;
        while (sent < 450) begin
            if ($urandom_range(0, 15) == 0) begin
                k = $urandom_range(0, 1);
                set_kind(k);
            end
            m = random_message(kind_q);
            // corrupt some messages at a random byte
            if ($urandom_range(0, 4) == 0) m[$urandom_range(0, m.len() - 1)] = 8'($urandom);
            for (int i = 0; i < m.len(); i++) send_byte(m[i], i == 0);
            sent += m.len();
            // raw noise, with a random start_new flag on each byte
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom), $urandom_range(0, 1));
                    sent++;
                end
            if (sent % 7 == 0) drain();
        end
    endtask

    initial begin
        kind_q = 1'b0;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_responses();
        test_requests();
        set_kind(1'b0);
        test_random_traffic();
        drain();
        repeat (20) @(posedge aclk);
        $display("tb: %0d results checked over response and request parsing,", results_seen);
        $display("tb: length and chunked bodies, errors, folding and noise");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
